### hw/rtl/miie_pkg.sv
// Package for the MIPS immediate-format execute block.
// Holds opcode, status and memory-request codes and the result record type.
// No dependencies.
package miie_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned INSN_W    = 32;
  localparam int unsigned IMM_W     = 16;
  localparam int unsigned IMM_SHIFT = 16;
  localparam int unsigned REG_IDX_W = 5;

  // Opcode field, bits [31:26]
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BLEZ  = 6'h06;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_XORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_BEQL  = 6'h14;
  localparam logic [5:0] OP_BNEL  = 6'h15;
  localparam logic [5:0] OP_BLEZL = 6'h16;
  localparam logic [5:0] OP_BGTZL = 6'h17;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_LL    = 6'h30;
  localparam logic [5:0] OP_SC    = 6'h38;

  // Likely branches have this opcode bit set
  localparam int unsigned LIKELY_BIT = 4;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd1;
  localparam logic [2:0] STAT_LOAD_ADE  = 3'd2;
  localparam logic [2:0] STAT_STORE_ADE = 3'd3;
  localparam logic [2:0] STAT_UNHANDLED = 3'd4;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  typedef struct packed {
    logic [2:0]           status;
    logic                 reg_write;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [XLEN-1:0]      reg_value;
    logic                 branch_taken;
    logic                 branch_likely;
    logic [1:0]           mem_op;
    logic [1:0]           mem_size;
    logic                 load_signed;
    logic [XLEN-1:0]      mem_address;
    logic [31:0]          store_data;
  } result_t;

endpackage

### hw/rtl/miie_exec.sv
// Combinational execute unit: decodes one I-type instruction and forms its result.
// Depends on miie_pkg for opcodes, codes and result_t.
module miie_exec (
  input  logic [31:0]          insn,
  input  logic [63:0]          rs_val,
  input  logic [63:0]          rt_val,
  input  logic                 link_valid,
  output miie_pkg::result_t    res,
  output logic                 link_set
);

  logic [5:0]  op;
  logic [4:0]  rt_idx;
  logic [63:0] zimm;
  logic [63:0] simm;
  logic [63:0] addr;
  logic [31:0] sum32;
  logic        add_ovf;
  logic        likely;
  logic        rs_zero;

  assign op      = insn[31:26];
  assign rt_idx  = insn[20:16];
  assign zimm    = {48'd0, insn[15:0]};
  assign simm    = {{48{insn[15]}}, insn[15:0]};
  // One adder serves ADDI, ADDIU and the effective address
  assign addr    = rs_val + simm;
  assign sum32   = addr[31:0];
  assign add_ovf = (rs_val[31] == simm[31]) && (sum32[31] != rs_val[31]);
  assign likely  = op[miie_pkg::LIKELY_BIT];
  assign rs_zero = (rs_val == 64'd0);

  always_comb begin
    res      = '0;
    link_set = 1'b0;
    case (op)
      miie_pkg::OP_BEQ, miie_pkg::OP_BEQL: begin
        res.branch_taken  = (rs_val == rt_val);
        res.branch_likely = likely;
      end
      miie_pkg::OP_BNE, miie_pkg::OP_BNEL: begin
        res.branch_taken  = (rs_val != rt_val);
        res.branch_likely = likely;
      end
      miie_pkg::OP_BLEZ, miie_pkg::OP_BLEZL: begin
        res.branch_taken  = rs_zero || rs_val[63];
        res.branch_likely = likely;
      end
      miie_pkg::OP_BGTZ, miie_pkg::OP_BGTZL: begin
        res.branch_taken  = !rs_zero && !rs_val[63];
        res.branch_likely = likely;
      end
      miie_pkg::OP_ADDI: begin
        if (add_ovf) begin
          res.status = miie_pkg::STAT_OVERFLOW;
        end else begin
          res.reg_write = 1'b1;
          res.dest_reg  = rt_idx;
          res.reg_value = {{32{sum32[31]}}, sum32};
        end
      end
      miie_pkg::OP_ADDIU: begin
        res.reg_write = 1'b1;
        res.dest_reg  = rt_idx;
        res.reg_value = {{32{sum32[31]}}, sum32};
      end
      miie_pkg::OP_SLTI: begin
        res.reg_write = 1'b1;
        res.dest_reg  = rt_idx;
        res.reg_value = {63'd0, ($signed(rs_val) < $signed(simm))};
      end
      miie_pkg::OP_SLTIU: begin
        res.reg_write = 1'b1;
        res.dest_reg  = rt_idx;
        res.reg_value = {63'd0, (rs_val < simm)};
      end
      miie_pkg::OP_ANDI: begin
        res.reg_write = 1'b1;
        res.dest_reg  = rt_idx;
        res.reg_value = rs_val & zimm;
      end
      miie_pkg::OP_ORI: begin
        res.reg_write = 1'b1;
        res.dest_reg  = rt_idx;
        res.reg_value = rs_val | zimm;
      end
      miie_pkg::OP_XORI: begin
        res.reg_write = 1'b1;
        res.dest_reg  = rt_idx;
        res.reg_value = rs_val ^ zimm;
      end
      miie_pkg::OP_LUI: begin
        res.reg_write = 1'b1;
        res.dest_reg  = rt_idx;
        res.reg_value = {{32{insn[15]}}, insn[15:0], 16'd0};
      end
      miie_pkg::OP_LB, miie_pkg::OP_LBU: begin
        res.mem_address = addr;
        res.mem_size    = miie_pkg::SIZE_BYTE;
        res.mem_op      = miie_pkg::MEM_READ;
        res.dest_reg    = rt_idx;
        res.load_signed = (op != miie_pkg::OP_LBU);
      end
      miie_pkg::OP_LH, miie_pkg::OP_LHU: begin
        res.mem_address = addr;
        res.mem_size    = miie_pkg::SIZE_HALF;
        if (addr[0]) begin
          res.status = miie_pkg::STAT_LOAD_ADE;
        end else begin
          res.mem_op      = miie_pkg::MEM_READ;
          res.dest_reg    = rt_idx;
          res.load_signed = (op != miie_pkg::OP_LHU);
        end
      end
      miie_pkg::OP_LW, miie_pkg::OP_LL: begin
        res.mem_address = addr;
        res.mem_size    = miie_pkg::SIZE_WORD;
        if (addr[1:0] != 2'd0) begin
          res.status = miie_pkg::STAT_LOAD_ADE;
        end else begin
          res.mem_op      = miie_pkg::MEM_READ;
          res.dest_reg    = rt_idx;
          res.load_signed = 1'b1;
          link_set        = (op == miie_pkg::OP_LL);
        end
      end
      miie_pkg::OP_SB: begin
        res.mem_address = addr;
        res.mem_size    = miie_pkg::SIZE_BYTE;
        res.mem_op      = miie_pkg::MEM_WRITE;
        res.store_data  = rt_val[31:0];
      end
      miie_pkg::OP_SH: begin
        res.mem_address = addr;
        res.mem_size    = miie_pkg::SIZE_HALF;
        if (addr[0]) begin
          res.status = miie_pkg::STAT_STORE_ADE;
        end else begin
          res.mem_op     = miie_pkg::MEM_WRITE;
          res.store_data = rt_val[31:0];
        end
      end
      miie_pkg::OP_SW: begin
        res.mem_address = addr;
        res.mem_size    = miie_pkg::SIZE_WORD;
        if (addr[1:0] != 2'd0) begin
          res.status = miie_pkg::STAT_STORE_ADE;
        end else begin
          res.mem_op     = miie_pkg::MEM_WRITE;
          res.store_data = rt_val[31:0];
        end
      end
      miie_pkg::OP_SC: begin
        res.mem_address = addr;
        res.mem_size    = miie_pkg::SIZE_WORD;
        // failed SC: rt gets 0, no alignment check
        if (!link_valid) begin
          res.reg_write = 1'b1;
          res.dest_reg  = rt_idx;
        end else if (addr[1:0] != 2'd0) begin
          res.status = miie_pkg::STAT_STORE_ADE;
        end else begin
          res.mem_op     = miie_pkg::MEM_WRITE;
          res.store_data = rt_val[31:0];
          res.reg_write  = 1'b1;
          res.dest_reg   = rt_idx;
          res.reg_value  = 64'd1;
        end
      end
      default: begin
        res.status = miie_pkg::STAT_UNHANDLED;
      end
    endcase
  end

endmodule

### hw/rtl/mips_immediate_instruction_execute.sv
// Top level of the MIPS immediate-format execute block.
// Depends on miie_pkg and miie_exec.
//
// Executes one I-type instruction per item and returns one result item for it:
// an ALU write-back, a branch decision, a memory request or an error status. An
// item is registered on entry, decoded and executed by one combinational pass
// (a single 64-bit adder shared by ADDI, ADDIU and address generation), and the
// result is registered on the way out, so out_valid rises as the item moves from
// the input registers into the result register, and one item is taken every cycle
// while the result side keeps up. The LL link bit is updated as an item moves into
// the result register, so an SC sees every LL accepted before it; only reset
// clears it.
module mips_immediate_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  input  logic [63:0] in_rs_value,
  input  logic [63:0] in_rt_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_reg_write,
  output logic [4:0]  out_dest_reg,
  output logic [63:0] out_reg_value,
  output logic        out_branch_taken,
  output logic        out_branch_likely,
  output logic [1:0]  out_mem_op,
  output logic [1:0]  out_mem_size,
  output logic        out_load_signed,
  output logic [63:0] out_mem_address,
  output logic [31:0] out_store_data
);

  logic               in_valid_r;
  logic [31:0]        insn_r;
  logic [63:0]        rs_r;
  logic [63:0]        rt_r;
  logic               link_valid_r;
  logic               link_valid_nxt;
  logic               out_valid_r;
  miie_pkg::result_t  res_r;
  miie_pkg::result_t  res_nxt;
  logic               link_set;
  logic               advance;
  logic               in_fire;

  // Stage 1 moves on whenever the result register is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  miie_exec u_exec (
    .insn       (insn_r),
    .rs_val     (rs_r),
    .rt_val     (rt_r),
    .link_valid (link_valid_r),
    .res        (res_nxt),
    .link_set   (link_set)
  );

  assign link_valid_nxt = link_valid_r || (in_valid_r && advance && link_set);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      link_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      link_valid_r <= link_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      insn_r <= in_instruction;
      rs_r   <= in_rs_value;
      rt_r   <= in_rt_value;
    end
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_reg_write     = res_r.reg_write;
  assign out_dest_reg      = res_r.dest_reg;
  assign out_reg_value     = res_r.reg_value;
  assign out_branch_taken  = res_r.branch_taken;
  assign out_branch_likely = res_r.branch_likely;
  assign out_mem_op        = res_r.mem_op;
  assign out_mem_size      = res_r.mem_size;
  assign out_load_signed   = res_r.load_signed;
  assign out_mem_address   = res_r.mem_address;
  assign out_store_data    = res_r.store_data;

  // Link bit is only ever cleared by reset
  a_link_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(link_valid_r))
    else $error("link bit dropped without reset");

  // Input side stalls only when both stages hold an item and the output is blocked
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  // An error status never comes with a memory request or a write-back
  a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != miie_pkg::STAT_OK)
      |-> (out_mem_op == miie_pkg::MEM_NONE && !out_reg_write))
    else $error("error status with side effects");

  // A successful SC write needs the link bit set by an earlier LL
  a_sc_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && advance && insn_r[31:26] == miie_pkg::OP_SC
      && res_nxt.mem_op == miie_pkg::MEM_WRITE) |-> link_valid_r)
    else $error("SC stored without link");

endmodule

### test/mips_immediate_instruction_execute_tb.sv
// Testbench for mips_immediate_instruction_execute: directed and random I-type items,
// with results checked in order against a behavioral predictor held in a scoreboard.
// Depends on miie_pkg and the block's RTL.
`timescale 1ns / 100ps

module mips_immediate_instruction_execute_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned HOLD_AT_ITEM = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 10;

  localparam logic [5:0] HANDLED_OPS [26] = '{
    miie_pkg::OP_BEQ, miie_pkg::OP_BNE, miie_pkg::OP_BLEZ, miie_pkg::OP_BGTZ,
    miie_pkg::OP_ADDI, miie_pkg::OP_ADDIU, miie_pkg::OP_SLTI, miie_pkg::OP_SLTIU,
    miie_pkg::OP_ANDI, miie_pkg::OP_ORI, miie_pkg::OP_XORI, miie_pkg::OP_LUI,
    miie_pkg::OP_BEQL, miie_pkg::OP_BNEL, miie_pkg::OP_BLEZL, miie_pkg::OP_BGTZL,
    miie_pkg::OP_LB, miie_pkg::OP_LH, miie_pkg::OP_LW, miie_pkg::OP_LBU,
    miie_pkg::OP_LHU, miie_pkg::OP_SB, miie_pkg::OP_SH, miie_pkg::OP_SW,
    miie_pkg::OP_LL, miie_pkg::OP_SC
  };

  // In-order store of predicted results plus the LL link bit.
  class exec_scoreboard;
    miie_pkg::result_t pending[$];
    bit                link_set;
    int unsigned       errors;

    function new();
      link_set = 1'b0;
      errors   = 0;
    endfunction

    function miie_pkg::result_t execute(logic [31:0] insn, logic [63:0] rs,
                                        logic [63:0] rt);
      miie_pkg::result_t r;
      logic [5:0]  op;
      logic [63:0] zimm;
      logic [63:0] simm;
      logic [63:0] addr;
      logic [31:0] sum32;
      r     = '0;
      op    = insn[31:26];
      zimm  = {48'h0, insn[15:0]};
      simm  = {{48{insn[15]}}, insn[15:0]};
      addr  = rs + simm;
      sum32 = rs[31:0] + simm[31:0];
      case (op)
        miie_pkg::OP_BEQ, miie_pkg::OP_BEQL, miie_pkg::OP_BNE, miie_pkg::OP_BNEL,
        miie_pkg::OP_BLEZ, miie_pkg::OP_BLEZL, miie_pkg::OP_BGTZ,
        miie_pkg::OP_BGTZL: begin
          r.branch_likely = op[miie_pkg::LIKELY_BIT];
          case (op)
            miie_pkg::OP_BEQ, miie_pkg::OP_BEQL:   r.branch_taken = (rs == rt);
            miie_pkg::OP_BNE, miie_pkg::OP_BNEL:   r.branch_taken = (rs != rt);
            miie_pkg::OP_BLEZ, miie_pkg::OP_BLEZL:
              r.branch_taken = (rs == 64'h0) || rs[63];
            default: r.branch_taken = (rs != 64'h0) && !rs[63];
          endcase
        end
        miie_pkg::OP_ADDI, miie_pkg::OP_ADDIU: begin
          // signed 32-bit overflow traps ADDI only
          if (op == miie_pkg::OP_ADDI && rs[31] == simm[31] && sum32[31] != rs[31]) begin
            r.status = miie_pkg::STAT_OVERFLOW;
          end else begin
            r.reg_write = 1'b1;
            r.dest_reg  = insn[20:16];
            r.reg_value = {{32{sum32[31]}}, sum32};
          end
        end
        miie_pkg::OP_SLTI, miie_pkg::OP_SLTIU, miie_pkg::OP_ANDI, miie_pkg::OP_ORI,
        miie_pkg::OP_XORI, miie_pkg::OP_LUI: begin
          r.reg_write = 1'b1;
          r.dest_reg  = insn[20:16];
          case (op)
            miie_pkg::OP_SLTI:  r.reg_value = {63'h0, $signed(rs) < $signed(simm)};
            miie_pkg::OP_SLTIU: r.reg_value = {63'h0, rs < simm};
            miie_pkg::OP_ANDI:  r.reg_value = rs & zimm;
            miie_pkg::OP_ORI:   r.reg_value = rs | zimm;
            miie_pkg::OP_XORI:  r.reg_value = rs ^ zimm;
            default:            r.reg_value = {{32{insn[15]}}, insn[15:0], 16'h0};
          endcase
        end
        miie_pkg::OP_LB, miie_pkg::OP_LBU, miie_pkg::OP_LH, miie_pkg::OP_LHU,
        miie_pkg::OP_LW, miie_pkg::OP_LL: begin
          r.mem_address = addr;
          r.mem_size = (op == miie_pkg::OP_LB || op == miie_pkg::OP_LBU) ?
                         miie_pkg::SIZE_BYTE :
                       (op == miie_pkg::OP_LH || op == miie_pkg::OP_LHU) ?
                         miie_pkg::SIZE_HALF : miie_pkg::SIZE_WORD;
          if ((r.mem_size == miie_pkg::SIZE_HALF && addr[0]) ||
              (r.mem_size == miie_pkg::SIZE_WORD && addr[1:0] != 2'b00)) begin
            r.status = miie_pkg::STAT_LOAD_ADE;
          end else begin
            r.mem_op      = miie_pkg::MEM_READ;
            r.dest_reg    = insn[20:16];
            r.load_signed = (op != miie_pkg::OP_LBU && op != miie_pkg::OP_LHU);
            if (op == miie_pkg::OP_LL) link_set = 1'b1;
          end
        end
        miie_pkg::OP_SB, miie_pkg::OP_SH, miie_pkg::OP_SW: begin
          r.mem_address = addr;
          r.mem_size = (op == miie_pkg::OP_SB) ? miie_pkg::SIZE_BYTE :
                       (op == miie_pkg::OP_SH) ? miie_pkg::SIZE_HALF :
                       miie_pkg::SIZE_WORD;
          if ((r.mem_size == miie_pkg::SIZE_HALF && addr[0]) ||
              (r.mem_size == miie_pkg::SIZE_WORD && addr[1:0] != 2'b00)) begin
            r.status = miie_pkg::STAT_STORE_ADE;
          end else begin
            r.mem_op     = miie_pkg::MEM_WRITE;
            r.store_data = rt[31:0];
          end
        end
        miie_pkg::OP_SC: begin
          r.mem_address = addr;
          r.mem_size    = miie_pkg::SIZE_WORD;
          // without a link the SC fails quietly: rt gets 0, no alignment check
          if (!link_set) begin
            r.reg_write = 1'b1;
            r.dest_reg  = insn[20:16];
          end else if (addr[1:0] != 2'b00) begin
            r.status = miie_pkg::STAT_STORE_ADE;
          end else begin
            r.mem_op     = miie_pkg::MEM_WRITE;
            r.store_data = rt[31:0];
            r.reg_write  = 1'b1;
            r.dest_reg   = insn[20:16];
            r.reg_value  = 64'h1;
          end
        end
        default: r.status = miie_pkg::STAT_UNHANDLED;
      endcase
      return r;
    endfunction

    function void note_issue(logic [31:0] insn, logic [63:0] rs, logic [63:0] rt);
      pending.push_back(execute(insn, rs, rt));
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(miie_pkg::result_t got);
      miie_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("reg_write", 64'(want.reg_write), 64'(got.reg_write));
      compare_field("dest_reg", 64'(want.dest_reg), 64'(got.dest_reg));
      compare_field("reg_value", want.reg_value, got.reg_value);
      compare_field("branch_taken", 64'(want.branch_taken), 64'(got.branch_taken));
      compare_field("branch_likely", 64'(want.branch_likely), 64'(got.branch_likely));
      compare_field("mem_op", 64'(want.mem_op), 64'(got.mem_op));
      compare_field("mem_size", 64'(want.mem_size), 64'(got.mem_size));
      compare_field("load_signed", 64'(want.load_signed), 64'(got.load_signed));
      compare_field("mem_address", want.mem_address, got.mem_address);
      compare_field("store_data", 64'(want.store_data), 64'(got.store_data));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_instruction;
  logic [63:0] in_rs_value;
  logic [63:0] in_rt_value;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic        out_reg_write;
  logic [4:0]  out_dest_reg;
  logic [63:0] out_reg_value;
  logic        out_branch_taken;
  logic        out_branch_likely;
  logic [1:0]  out_mem_op;
  logic [1:0]  out_mem_size;
  logic        out_load_signed;
  logic [63:0] out_mem_address;
  logic [31:0] out_store_data;

  exec_scoreboard sb = new();
  int unsigned    issued = 0;
  int unsigned    burst_left = 0;
  int unsigned    cycles = 0;

  mips_immediate_instruction_execute DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_instruction    (in_instruction),
    .in_rs_value       (in_rs_value),
    .in_rt_value       (in_rt_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_reg_write     (out_reg_write),
    .out_dest_reg      (out_dest_reg),
    .out_reg_value     (out_reg_value),
    .out_branch_taken  (out_branch_taken),
    .out_branch_likely (out_branch_likely),
    .out_mem_op        (out_mem_op),
    .out_mem_size      (out_mem_size),
    .out_load_signed   (out_load_signed),
    .out_mem_address   (out_mem_address),
    .out_store_data    (out_store_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : handshake_monitor
    miie_pkg::result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_issue(in_instruction, in_rs_value, in_rt_value);
      if (out_valid && out_ready) begin
        got.status        = out_status;
        got.reg_write     = out_reg_write;
        got.dest_reg      = out_dest_reg;
        got.reg_value     = out_reg_value;
        got.branch_taken  = out_branch_taken;
        got.branch_likely = out_branch_likely;
        got.mem_op        = out_mem_op;
        got.mem_size      = out_mem_size;
        got.load_signed   = out_load_signed;
        got.mem_address   = out_mem_address;
        got.store_data    = out_store_data;
        sb.check_result(got);
      end
    end
  end

  // Result side: random stall patterns, plus one long hold-off to back the block up.
  initial begin : result_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          held;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && issued >= HOLD_AT_ITEM) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // Offer one item and hold it until taken; bursts end in a random gap.
  task automatic issue(input logic [31:0] insn, input logic [63:0] rs, input logic [63:0] rt);
    int unsigned gap;
    in_valid       <= 1'b1;
    in_instruction <= insn;
    in_rs_value    <= rs;
    in_rt_value    <= rt;
    do @(posedge clk); while (!in_ready);
    issued++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic issue_op(input logic [5:0] op, input logic [4:0] rt_idx,
                          input logic [15:0] imm, input logic [63:0] rs,
                          input logic [63:0] rt);
    issue({op, 5'($urandom), rt_idx, imm}, rs, rt);
  endtask

  // Register values biased toward sign and 32-bit overflow boundaries.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 64'h0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h7FFF_FFFF_FFFF_FFFF;
      4:       return {$urandom, 32'h7FFF_FFFF - $urandom_range(0, 40000)};
      5:       return {$urandom, 32'h8000_0000 + $urandom_range(0, 40000)};
      6:       return 64'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic issue_random();
    logic [5:0]  op;
    logic [15:0] imm;
    logic [63:0] rs;
    logic [63:0] rt;
    op  = ($urandom_range(0, 9) == 0) ? 6'($urandom) : HANDLED_OPS[$urandom_range(0, 25)];
    imm = pick_imm();
    rs  = pick_value();
    rt  = pick_value();
    // half of memory ops get an aligned effective address
    if (op[5] && $urandom_range(0, 1) == 1) rs[1:0] = 2'b00 - imm[1:0];
    if (!op[5] && $urandom_range(0, 3) == 0) rt = rs;
    issue({op, 5'($urandom), 5'($urandom), imm}, rs, rt);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_instruction = '0;
    in_rs_value    = '0;
    in_rt_value    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // link bit is only clear right after reset, so SC-without-link goes first
    issue_op(miie_pkg::OP_SC, 5'd5, 16'h0000, 64'h1000, 64'hDEAD_BEEF_1234_5678);
    issue_op(miie_pkg::OP_SC, 5'd6, 16'h0003, 64'h1000, '1);
    issue_op(miie_pkg::OP_LL, 5'd7, 16'h0002, 64'h2000, '0);
    issue_op(miie_pkg::OP_SC, 5'd8, 16'h0001, 64'h2000, '1);
    issue_op(miie_pkg::OP_LL, 5'd9, 16'hFFFC, 64'h2000, '0);
    issue_op(miie_pkg::OP_SC, 5'd31, 16'h0004, 64'h2000, '1);
    issue_op(miie_pkg::OP_SC, 5'd0, 16'h0002, 64'h2000, '1);
    issue_op(miie_pkg::OP_ADDI, 5'd1, 16'h0001, 64'h0000_0000_7FFF_FFFF, '0);
    issue_op(miie_pkg::OP_ADDI, 5'd2, 16'hFFFF, 64'hFFFF_FFFF_8000_0000, '0);
    issue_op(miie_pkg::OP_ADDIU, 5'd3, 16'h7FFF, '1, '0);
    issue_op(miie_pkg::OP_SLTI, 5'd4, 16'h7FFF, 64'h8000_0000_0000_0000, '0);
    issue_op(miie_pkg::OP_SLTIU, 5'd10, 16'hFFFF, '1, '0);
    issue_op(miie_pkg::OP_ANDI, 5'd11, 16'hFFFF, '1, '0);
    issue_op(miie_pkg::OP_ORI, 5'd12, 16'h8000, '0, '0);
    issue_op(miie_pkg::OP_XORI, 5'd13, 16'hAAAA, '1, '0);
    issue_op(miie_pkg::OP_LUI, 5'd14, 16'h8000, '0, '0);
    issue_op(miie_pkg::OP_BEQ, 5'd15, 16'h0010, 64'd123, 64'd123);
    issue_op(miie_pkg::OP_BNEL, 5'd16, 16'hFFF0, 64'd1, 64'd2);
    issue_op(miie_pkg::OP_BLEZL, 5'd17, 16'h0000, 64'h8000_0000_0000_0000, '0);
    issue_op(miie_pkg::OP_BGTZ, 5'd18, 16'h0000, 64'h0, '0);
    issue_op(miie_pkg::OP_LB, 5'd19, 16'h0001, '1, '0);
    issue_op(miie_pkg::OP_LHU, 5'd20, 16'h0001, 64'h4000, '0);
    issue_op(miie_pkg::OP_LW, 5'd21, 16'hFFF8, 64'h7FFF_FFFF_FFFF_FFF8, '0);
    issue_op(miie_pkg::OP_SH, 5'd22, 16'h0003, 64'h4000, '1);
    issue_op(miie_pkg::OP_SW, 5'd23, 16'h0000, 64'h4000, 64'hFFFF_FFFF_0000_0001);
    issue_op(6'h00, 5'd24, 16'hFFFF, '1, '1);
    issue_op(6'h3F, 5'd25, 16'h1234, '1, '1);

    repeat (RANDOM_ITEMS) issue_random();
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
